// ----- src/scu_pkg.sv -----
// Shared constants, codes and types of the sonar ping and echo capture unit.
`default_nettype none
package scu_pkg;

  localparam int ECHO_DEPTH = 512;
  localparam int IDX_W      = $clog2(ECHO_DEPTH);
  localparam int ECHO_LANES = 2;
  localparam int LANE_W     = $clog2(ECHO_LANES);
  localparam int ECHO_ROWS  = ECHO_DEPTH / ECHO_LANES;
  localparam int ROW_W      = $clog2(ECHO_ROWS);
  localparam int BIN_W      = 8;
  localparam int ROW_DATA_W = ECHO_LANES * BIN_W;

  localparam int ACT_W      = 3;
  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 12;
  localparam int DRIVE_W    = 2;
  localparam int PULSE_W    = 8;
  localparam int PING_W     = 8;
  localparam int PIXEL_W    = 16;
  localparam int RANGE_W    = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_START   = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_SAMPLE  = 3'd2,
    ACT_GAIN_WR = 3'd3,
    ACT_READ    = 3'd4
  } act_e_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PING = 3'b010,
    PH_CAP  = 3'b100
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] REG_PING_PULSES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PING_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_INDEX  = 2'd3;

  localparam logic [DRIVE_W-1:0] DRV_PIN_A = 2'd1;
  localparam logic [DRIVE_W-1:0] DRV_PIN_B = 2'd2;
  localparam logic [DRIVE_W-1:0] DRV_OFF   = 2'd3;

  // Work handed from the sequencer stage to the echo/result stage
  typedef struct packed {
    logic                 peak_wr;
    logic                 run_end;
    logic                 echo_rd;
    logic                 gain_load;
    logic [LANE_W-1:0]    lane;
    logic [ROW_W-1:0]     row;
    logic [BIN_W-1:0]     level;
    logic [DRIVE_W-1:0]   drive;
    logic                 busy;
    logic                 done;
  } stage_ctl_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [GAIN_W-1:0] val;
  } gain_wr_t;

endpackage
`default_nettype wire

// ----- src/scu_if.sv -----
// Channel interfaces: input item, result item and configuration write.
`default_nettype none
interface scu_in_if;
  import scu_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]    entry_index;
  logic [GAIN_W-1:0]   gain_value;
  modport source (output valid, action, sample, entry_index, gain_value, input ready);
  modport sink (input valid, action, sample, entry_index, gain_value, output ready);
endinterface

interface scu_out_if;
  import scu_pkg::*;
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] ping_drive;
  logic [GAIN_W-1:0]  gain_level;
  logic               busy_res;
  logic               done_res;
  logic [BIN_W-1:0]   read_data;
  modport source (output valid, ping_drive, gain_level, busy_res, done_res, read_data,
                  input ready);
  modport sink (input valid, ping_drive, gain_level, busy_res, done_res, read_data,
                output ready);
endinterface

interface scu_cfg_if;
  import scu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/sonar_ping_and_echo_capture_unit.sv -----
// Top level of the sonar ping and echo capture unit.
// Usage:
//   in_if  : one item per handshake (start, tick, ADC sample, gain table write,
//            echo read); valid/ready, accepted when both are high.
//   out_if : one result item per input item, in order: drive pins, gain word,
//            busy, done and echo read data.
//   cfg_if : register writes (pulse pairs, ping period, pixel period, range
//            code); always ready, write only while the unit is idle.
// After its item is accepted, a result passes the input register, the echo/gain
// memory read register and the result register before it is valid.
// Throughput is one item per cycle while in_if.ready is high, set by the echo row
// memory, read and written once per cycle, its read-modify-write forwarded between
// neighbouring items. After reset all 512 gain entries are swept to zero, one per
// cycle; in_if.ready stays low during the sweep while cfg_if is still served.
// When out_if.ready is low the result register holds, the two inner stages
// fill up and in_if.ready drops; nothing is lost or repeated.
`default_nettype none
module sonar_ping_and_echo_capture_unit (
  input wire logic clk,
  input wire logic rst_n,
  scu_in_if.sink   in_if,
  scu_out_if.source out_if,
  scu_cfg_if.sink  cfg_if
);
  import scu_pkg::*;

  logic [PULSE_W-1:0]  ping_pulses_r;
  logic [PING_W-1:0]   ping_period_r;
  logic [PIXEL_W-1:0]  pixel_period_r;
  logic [RANGE_W-1:0]  range_index_r;

  logic                s1_v_r;
  logic [ACT_W-1:0]    s1_action_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic [GAIN_W-1:0]   s1_gval_r;

  logic                s2_v_r;
  stage_ctl_t          s2_ctl_r;
  logic [GAIN_W-1:0]   gain_out_r, gain_out_nxt;

  logic                out_v_r;
  logic [DRIVE_W-1:0]  out_drive_r;
  logic [GAIN_W-1:0]   out_gain_r;
  logic                out_busy_r;
  logic                out_done_r;
  logic [BIN_W-1:0]    out_rdata_r;

  logic                s1_adv, s2_adv, in_acc, clearing, start;
  stage_ctl_t          ctl;
  gain_wr_t            gwr;
  logic [IDX_W-1:0]    gain_idx;
  logic [GAIN_W-1:0]   gain_rd;
  logic [BIN_W-1:0]    read_data;

  assign s2_adv      = s2_v_r && (!out_v_r || out_if.ready);
  assign s1_adv      = s1_v_r && (!s2_v_r || s2_adv);
  assign in_if.ready = !clearing && (!s1_v_r || s1_adv);
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_pulses_r  <= '0;
      ping_period_r  <= '0;
      pixel_period_r <= '0;
      range_index_r  <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_PING_PULSES:  ping_pulses_r  <= cfg_if.data[PULSE_W-1:0];
        REG_PING_PERIOD:  ping_period_r  <= cfg_if.data[PING_W-1:0];
        REG_PIXEL_PERIOD: pixel_period_r <= cfg_if.data[PIXEL_W-1:0];
        REG_RANGE_INDEX:  range_index_r  <= cfg_if.data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  scu_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (s1_adv),
    .action       (s1_action_r),
    .sample       (s1_sample_r),
    .entry_index  (s1_idx_r),
    .gain_value   (s1_gval_r),
    .ping_pulses  (ping_pulses_r),
    .ping_period  (ping_period_r),
    .pixel_period (pixel_period_r),
    .ctl          (ctl),
    .gwr          (gwr),
    .gain_idx     (gain_idx),
    .start        (start)
  );

  scu_gain u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_adv   (s1_adv),
    .gwr      (gwr),
    .rd_idx   (gain_idx),
    .gain_rd  (gain_rd),
    .clearing (clearing)
  );

  scu_echo u_echo (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_adv      (s1_adv),
    .start_clr   (s1_adv && start),
    .rd_row      (ctl.row),
    .s2_adv      (s2_adv),
    .s2_ctl      (s2_ctl_r),
    .range_index (range_index_r),
    .read_data   (read_data)
  );

  always_comb begin
    gain_out_nxt = gain_out_r;
    if (s2_ctl_r.run_end) begin
      gain_out_nxt = '0;
    end else if (s2_ctl_r.gain_load) begin
      gain_out_nxt = gain_rd;
    end
  end

  // valid flags and the held gain level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      gain_out_r <= '0;
    end else begin
      if (in_acc) s1_v_r <= 1'b1;
      else if (s1_adv) s1_v_r <= 1'b0;
      if (s1_adv) s2_v_r <= 1'b1;
      else if (s2_adv) s2_v_r <= 1'b0;
      if (s2_adv) out_v_r <= 1'b1;
      else if (out_if.ready) out_v_r <= 1'b0;
      if (s2_adv) gain_out_r <= gain_out_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_if.action;
      s1_sample_r <= in_if.sample;
      s1_idx_r    <= in_if.entry_index;
      s1_gval_r   <= in_if.gain_value;
    end
    if (s1_adv) s2_ctl_r <= ctl;
    if (s2_adv) begin
      out_drive_r <= s2_ctl_r.drive;
      out_gain_r  <= gain_out_nxt;
      out_busy_r  <= s2_ctl_r.busy;
      out_done_r  <= s2_ctl_r.done;
      out_rdata_r <= read_data;
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.ping_drive = out_drive_r;
  assign out_if.gain_level = out_gain_r;
  assign out_if.busy_res   = out_busy_r;
  assign out_if.done_res   = out_done_r;
  assign out_if.read_data  = out_rdata_r;

endmodule
`default_nettype wire

// ----- src/scu_seq.sv -----
// Ping/capture sequencer: phase, tick counters, bin index and drive level.
`default_nettype none
module scu_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic [scu_pkg::ACT_W-1:0]     action,
  input  wire logic [scu_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [scu_pkg::IDX_W-1:0]     entry_index,
  input  wire logic [scu_pkg::GAIN_W-1:0]    gain_value,
  input  wire logic [scu_pkg::PULSE_W-1:0]   ping_pulses,
  input  wire logic [scu_pkg::PING_W-1:0]    ping_period,
  input  wire logic [scu_pkg::PIXEL_W-1:0]   pixel_period,
  output scu_pkg::stage_ctl_t                ctl,
  output scu_pkg::gain_wr_t                  gwr,
  output logic [scu_pkg::IDX_W-1:0]          gain_idx,
  output logic                               start
);
  import scu_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [PULSE_W-1:0]   pulses_r, pulses_nxt;
  logic                 pin_b_r, pin_b_nxt;
  logic [PING_W-1:0]    ping_ticks_r, ping_ticks_nxt;
  logic [PIXEL_W-1:0]   pixel_ticks_r, pixel_ticks_nxt;
  logic [IDX_W-1:0]     bin_r, bin_nxt;
  logic [DRIVE_W-1:0]   drive_r, drive_nxt;
  logic [IDX_W:0]       bin_inc;

  assign bin_inc  = {1'b0, bin_r} + (IDX_W+1)'(1);
  assign gain_idx = bin_inc[IDX_W-1:0];

  always_comb begin
    phase_nxt       = phase_r;
    pulses_nxt      = pulses_r;
    pin_b_nxt       = pin_b_r;
    ping_ticks_nxt  = ping_ticks_r;
    pixel_ticks_nxt = pixel_ticks_r;
    bin_nxt         = bin_r;
    drive_nxt       = drive_r;
    start           = 1'b0;
    ctl             = '0;
    ctl.lane        = bin_r[LANE_W-1:0];
    ctl.row         = bin_r[IDX_W-1:LANE_W];
    ctl.level       = sample[SAMPLE_W-1 -: BIN_W];
    gwr.en          = 1'b0;
    gwr.idx         = entry_index;
    gwr.val         = gain_value;
    case (act_e_t'(action))
      ACT_START: begin
        start           = 1'b1;
        bin_nxt         = '0;
        ping_ticks_nxt  = '0;
        pixel_ticks_nxt = '0;
        pin_b_nxt       = 1'b0;
        pulses_nxt      = ping_pulses;
        phase_nxt       = PH_PING;
      end
      ACT_TICK: begin
        case (phase_r)
          PH_PING: begin
            if (ping_ticks_r >= ping_period) begin
              ping_ticks_nxt = '0;
              if (pulses_r != '0) begin
                if (!pin_b_r) begin
                  drive_nxt = DRV_PIN_A;
                  pin_b_nxt = 1'b1;
                end else begin
                  drive_nxt  = DRV_PIN_B;
                  pin_b_nxt  = 1'b0;
                  pulses_nxt = pulses_r - PULSE_W'(1);
                end
              end else begin
                drive_nxt       = DRV_OFF;
                phase_nxt       = PH_CAP;
                pixel_ticks_nxt = '0;
              end
            end else begin
              ping_ticks_nxt = ping_ticks_r + PING_W'(1);
            end
          end
          PH_CAP: begin
            if (pixel_ticks_r >= pixel_period) begin
              pixel_ticks_nxt = '0;
              if (bin_inc >= (IDX_W+1)'(ECHO_DEPTH)) begin
                // last bin done: stamp the range code into bin zero
                phase_nxt   = PH_IDLE;
                ctl.run_end = 1'b1;
                ctl.done    = 1'b1;
                ctl.row     = '0;
                ctl.lane    = '0;
              end else begin
                bin_nxt       = bin_inc[IDX_W-1:0];
                ctl.gain_load = 1'b1;
              end
            end else begin
              pixel_ticks_nxt = pixel_ticks_r + PIXEL_W'(1);
            end
          end
          default: ;
        endcase
      end
      ACT_SAMPLE: begin
        if (phase_r == PH_CAP) ctl.peak_wr = 1'b1;
      end
      ACT_GAIN_WR: begin
        gwr.en = 1'b1;
      end
      ACT_READ: begin
        ctl.echo_rd = 1'b1;
        ctl.lane    = entry_index[LANE_W-1:0];
        ctl.row     = entry_index[IDX_W-1:LANE_W];
      end
      default: ;
    endcase
    ctl.drive = drive_nxt;
    ctl.busy  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      pulses_r      <= '0;
      pin_b_r       <= 1'b0;
      ping_ticks_r  <= '0;
      pixel_ticks_r <= '0;
      bin_r         <= '0;
      drive_r       <= DRV_OFF;
    end else if (adv) begin
      phase_r       <= phase_nxt;
      pulses_r      <= pulses_nxt;
      pin_b_r       <= pin_b_nxt;
      ping_ticks_r  <= ping_ticks_nxt;
      pixel_ticks_r <= pixel_ticks_nxt;
      bin_r         <= bin_nxt;
      drive_r       <= drive_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/scu_gain.sv -----
// Gain table memory with a clearing sweep after reset.
`default_nettype none
module scu_gain (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        s1_adv,
  input  wire scu_pkg::gain_wr_t           gwr,
  input  wire logic [scu_pkg::IDX_W-1:0]   rd_idx,
  output logic [scu_pkg::GAIN_W-1:0]       gain_rd,
  output logic                             clearing
);
  import scu_pkg::*;

  logic [GAIN_W-1:0] mem [ECHO_DEPTH];
  logic [IDX_W:0]    clr_cnt_r;
  logic [GAIN_W-1:0] gain_rd_r;

  assign clearing = !clr_cnt_r[IDX_W];
  assign gain_rd  = gain_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + (IDX_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt_r[IDX_W-1:0]] <= '0;
    end else if (s1_adv && gwr.en) begin
      mem[gwr.idx] <= gwr.val;
    end
    if (s1_adv) gain_rd_r <= mem[rd_idx];
  end

endmodule
`default_nettype wire

// ----- src/scu_echo.sv -----
// Echo bin memory: row valid bits, peak-hold update and readback.
`default_nettype none
module scu_echo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s1_adv,
  input  wire logic                          start_clr,
  input  wire logic [scu_pkg::ROW_W-1:0]     rd_row,
  input  wire logic                          s2_adv,
  input  wire scu_pkg::stage_ctl_t           s2_ctl,
  input  wire logic [scu_pkg::RANGE_W-1:0]   range_index,
  output logic [scu_pkg::BIN_W-1:0]          read_data
);
  import scu_pkg::*;

  logic [ROW_DATA_W-1:0] mem [ECHO_ROWS];
  logic [ECHO_ROWS-1:0]  row_vld_r;
  logic [ROW_DATA_W-1:0] row_data_r;
  logic                  row_ok_r;
  logic [ROW_DATA_W-1:0] cur;
  logic [ROW_DATA_W-1:0] wr_data;
  logic [BIN_W-1:0]      old;
  logic                  wr_en;

  assign cur   = row_ok_r ? row_data_r : '0;
  assign old   = cur[int'(s2_ctl.lane) * BIN_W +: BIN_W];
  assign wr_en = s2_adv && (s2_ctl.peak_wr || s2_ctl.run_end);

  always_comb begin
    wr_data = cur;
    if (s2_ctl.peak_wr && (s2_ctl.level > old)) begin
      wr_data[int'(s2_ctl.lane) * BIN_W +: BIN_W] = s2_ctl.level;
    end
    if (s2_ctl.run_end) wr_data[BIN_W-1:0] = range_index;
    read_data = s2_ctl.echo_rd ? old : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[s2_ctl.row] <= wr_data;
    if (s1_adv) begin
      // forward the row being written by the older item
      if (wr_en && (s2_ctl.row == rd_row)) begin
        row_data_r <= wr_data;
        row_ok_r   <= 1'b1;
      end else begin
        row_data_r <= mem[rd_row];
        row_ok_r   <= row_vld_r[rd_row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (start_clr) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[s2_ctl.row] <= 1'b1;
    end
  end

endmodule
`default_nettype wire
